/* rtl/midi_note_message_matcher_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the MIDI note message matcher
// ---------------------------------------------------------------------------
`ifndef MIDI_NOTE_MESSAGE_MATCHER_TOP_DEFINES_SVH
`define MIDI_NOTE_MESSAGE_MATCHER_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define MNMM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle
`define MNMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mnmm_pkg.sv */
// ---------------------------------------------------------------------------
// mnmm_pkg
// Shared types, constants and helpers of the MIDI note message matcher.
// ---------------------------------------------------------------------------
package mnmm_pkg;

  // Pattern register layout
  localparam int PAT_W      = 25;
  localparam int PAT_EN_BIT = 24;
  localparam int REG_COUNT  = 4;
  localparam int CFG_AW     = 2;

  // Default and range of the pattern table
  localparam int DEF_NUM_PATTERNS = 4;
  localparam int IDX_W            = 3;

  // Result word width, padded to whole bytes
  localparam int OUT_TDATA_W = 32;

  // Status byte kinds (upper nibble)
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

  // Data bytes held count codes
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_STATUS,
    ST_SCAN_DATA,
    ST_FLUSH
  } seq_state_t;

  // Compare unit result
  typedef struct packed {
    logic status_hit;
    logic full_hit;
  } match_res_t;

  // One result word from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [7:0]       status;
    logic [6:0]       d1;
    logic [6:0]       d2;
    logic             last;
  } push_t;

  // A pattern data byte with bit 7 set matches any value
  function automatic logic data_ok(input logic [7:0] want, input logic [6:0] got);
    return want[7] || (want == {1'b0, got});
  endfunction

endpackage

/* rtl/mnmm_match_unit.sv */
// ---------------------------------------------------------------------------
// mnmm_match_unit
// Shared compare unit: checks one pattern entry against a status byte and
// two data bytes.
// ---------------------------------------------------------------------------
module mnmm_match_unit
  import mnmm_pkg::*;
(
  input  logic [PAT_W-1:0] pattern,
  input  logic [7:0]       ref_status,
  input  logic [6:0]       ref_d1,
  input  logic [6:0]       ref_d2,
  output match_res_t       res
);

  // Enabled entry with the exact status byte
  assign res.status_hit = pattern[PAT_EN_BIT] && (pattern[23:16] == ref_status);

  // Status hit plus both data bytes equal or wildcarded
  assign res.full_hit = res.status_hit
                        && data_ok(pattern[15:8], ref_d1)
                        && data_ok(pattern[7:0], ref_d2);

endmodule

/* rtl/mnmm_seq.sv */
// ---------------------------------------------------------------------------
// mnmm_seq
// Parser state and scan sequencer: walks the pattern table one entry a
// cycle, while the output does not stall, through the shared compare unit and issues result words.
// ---------------------------------------------------------------------------
module mnmm_seq
  import mnmm_pkg::*;
#(
  parameter int NUM_PATTERNS = DEF_NUM_PATTERNS
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [7:0]       in_byte,
  output logic             in_ready,
  input  match_res_t       res,
  input  logic             can_push,
  output logic [IDX_W-1:0] scan_idx,
  output logic [7:0]       ref_status,
  output logic [6:0]       ref_d1,
  output logic [6:0]       ref_d2,
  output push_t            push
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PATTERNS - 1);

  seq_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             collecting_r, collecting_nxt;
  logic [1:0]       bytes_held_r, bytes_held_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [7:0]       held_status_r, held_status_nxt;
  logic [6:0]       held_d1_r, held_d1_nxt;
  logic             kind_ok;
  logic             stall;
  logic             at_last;

  assign kind_ok = (byte_r[7:4] == KIND_NOTE_ON) || (byte_r[7:4] == KIND_NOTE_OFF);
  assign at_last = (idx_r == LAST_IDX);
  // Hold the scan while a new hit finds a pending word that cannot leave
  assign stall   = res.full_hit && pend_v_r && !can_push;

  assign in_ready   = (state_r == ST_IDLE);
  assign scan_idx   = idx_r;
  assign ref_status = (state_r == ST_SCAN_STATUS) ? byte_r : held_status_r;
  assign ref_d1     = held_d1_r;
  assign ref_d2     = byte_r[6:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!collecting_r && in_byte[7]) begin
            state_nxt = ST_SCAN_STATUS;
          end else if (collecting_r && !in_byte[7] && bytes_held_r == HELD_ONE) begin
            state_nxt = ST_SCAN_DATA;
          end
        end
      end
      ST_SCAN_STATUS: begin
        if (res.status_hit || at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN_DATA: begin
        if (!stall && at_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r || can_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    idx_nxt         = idx_r;
    pend_v_nxt      = pend_v_r;
    pend_idx_nxt    = pend_idx_r;
    collecting_nxt  = collecting_r;
    bytes_held_nxt  = bytes_held_r;
    byte_nxt        = byte_r;
    held_status_nxt = held_status_r;
    held_d1_nxt     = held_d1_r;
    push.valid      = 1'b0;
    push.index      = pend_idx_r;
    push.status     = held_status_r;
    push.d1         = held_d1_r;
    push.d2         = byte_r[6:0];
    push.last       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          byte_nxt = in_byte;
          idx_nxt  = '0;
          pend_v_nxt = 1'b0;
          // First data byte of a message: latch it
          if (collecting_r && !in_byte[7] && bytes_held_r == HELD_NONE) begin
            held_d1_nxt    = in_byte[6:0];
            bytes_held_nxt = HELD_ONE;
          end
        end
      end
      ST_SCAN_STATUS: begin
        // First status hit decides; accept only note-on and note-off
        if (res.status_hit) begin
          if (kind_ok) begin
            held_status_nxt = byte_r;
            bytes_held_nxt  = HELD_NONE;
            collecting_nxt  = 1'b1;
          end
        end else if (!at_last) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SCAN_DATA: begin
        if (!stall) begin
          if (res.full_hit) begin
            // Release the earlier match; it is not the final one
            push.valid   = pend_v_r;
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = idx_r;
          end
          if (!at_last) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r || can_push) begin
          push.valid     = pend_v_r;
          push.last      = 1'b1;
          pend_v_nxt     = 1'b0;
          collecting_nxt = 1'b0;
          bytes_held_nxt = HELD_NONE;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      pend_v_r     <= 1'b0;
      collecting_r <= 1'b0;
      bytes_held_r <= HELD_NONE;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pend_v_r     <= pend_v_nxt;
      collecting_r <= collecting_nxt;
      bytes_held_r <= bytes_held_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_idx_r    <= pend_idx_nxt;
    byte_r        <= byte_nxt;
    held_status_r <= held_status_nxt;
    held_d1_r     <= held_d1_nxt;
  end

endmodule

/* rtl/midi_note_message_matcher_top.sv */
// ---------------------------------------------------------------------------
// midi_note_message_matcher_top
// MIDI note-on/note-off parser with a pattern table and match results.
// ---------------------------------------------------------------------------
// One received MIDI byte is taken per input word. A status byte is checked
// against the entries in table order up to the first status hit, the byte
// completing a message against every entry, one entry per cycle while the
// output side does not stall, since a single compare unit walks the table.
// Each matching entry yields one result word in table order; the final one of
// a message has out_tlast set. A result word may wait in the output register
// while the next byte is accepted. The user must write pattern registers
// through the cfg port while the block is idle; the block does not enforce it.
module midi_note_message_matcher_top
  import mnmm_pkg::*;
#(
  parameter int NUM_PATTERNS = DEF_NUM_PATTERNS
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] pattern_index, [10:3] status_byte, [17:11] first_data,
  // [24:18] second_data, [31:25] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,  // last_match
  input  logic                   cfg_wr_en,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [PAT_W-1:0]       cfg_wdata
);

  localparam int NUM_REGS = (NUM_PATTERNS < REG_COUNT) ? NUM_PATTERNS : REG_COUNT;

  logic [PAT_W-1:0]       pat_r [NUM_REGS];
  logic [PAT_W-1:0]       pat_nxt [NUM_REGS];
  logic [PAT_W-1:0]       pat_sel;
  logic                   in_fire;
  logic                   can_push;
  logic [IDX_W-1:0]       scan_idx;
  logic [7:0]             ref_status;
  logic [6:0]             ref_d1;
  logic [6:0]             ref_d2;
  match_res_t             res;
  push_t                  push;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  assign in_fire  = in_tvalid && in_tready;
  assign can_push = !out_valid_r || out_tready;

  // Pattern register writes
  always_comb begin
    for (int k = 0; k < NUM_REGS; k++) begin
      pat_nxt[k] = pat_r[k];
      if (cfg_wr_en && cfg_addr == CFG_AW'(k)) begin
        pat_nxt[k] = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        pat_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_REGS; k++) begin
        pat_r[k] <= pat_nxt[k];
      end
    end
  end

  // Select the entry under scan; entries without a register stay disabled
  always_comb begin
    pat_sel = '0;
    for (int k = 0; k < NUM_REGS; k++) begin
      if (scan_idx == IDX_W'(k)) begin
        pat_sel = pat_r[k];
      end
    end
  end

  mnmm_match_unit u_match (
    .pattern    (pat_sel),
    .ref_status (ref_status),
    .ref_d1     (ref_d1),
    .ref_d2     (ref_d2),
    .res        (res)
  );

  mnmm_seq #(
    .NUM_PATTERNS (NUM_PATTERNS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_byte    (in_tdata),
    .in_ready   (in_tready),
    .res        (res),
    .can_push   (can_push),
    .scan_idx   (scan_idx),
    .ref_status (ref_status),
    .ref_d1     (ref_d1),
    .ref_d2     (ref_d2),
    .push       (push)
  );

  // Output register: load a new word, drop a taken one
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (push.valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {(OUT_TDATA_W - IDX_W - 22)'(0),
                       push.d2, push.d1, push.status, push.index};
      out_last_nxt  = push.last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/mnmm_checker.sv */
// ---------------------------------------------------------------------------
// mnmm_checker
// Port-level checks of the MIDI note message matcher, bound to the top.
// ---------------------------------------------------------------------------
`include "midi_note_message_matcher_top_defines.svh"

module mnmm_checker
  import mnmm_pkg::*;
#(
  parameter int NUM_PATTERNS = DEF_NUM_PATTERNS
)
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PATTERNS - 1);

  // A stalled word holds
  `MNMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result word changed while stalled")

  // Reported index lies inside the table
  `MNMM_ASSERT_ALWAYS(a_index_range, clk, rst_n, !out_tvalid || out_tdata[2:0] <= LAST_IDX, "pattern index beyond table")

  // Reported status is a note-on or note-off status byte
  `MNMM_ASSERT_ALWAYS(a_status_kind, clk, rst_n, !out_tvalid || out_tdata[10:7] == KIND_NOTE_ON || out_tdata[10:7] == KIND_NOTE_OFF, "result status is not a note message")

  // Padding bits stay zero
  `MNMM_ASSERT_ALWAYS(a_pad_zero, clk, rst_n, !out_tvalid || out_tdata[OUT_TDATA_W-1:25] == '0, "padding bits set in result word")

endmodule

bind midi_note_message_matcher_top mnmm_checker #(
  .NUM_PATTERNS (NUM_PATTERNS)
) u_mnmm_checker (.*);
